// ----- design/hbd_pkg.sv -----
// ----------------------------------------------------------------------------
// hbd_pkg: shared types and constants for the HTTP body dechunker
// Item layouts, phase encoding, result and error codes, hex digit decode.
// ----------------------------------------------------------------------------
package hbd_pkg;

  localparam int unsigned DeclLenW = 32;

  // input item kinds (the fourth code is ignored)
  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_DATA  = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;

  localparam logic [7:0] CH_CR   = 8'h0d;
  localparam logic [7:0] CH_LF   = 8'h0a;
  localparam logic [7:0] CH_0    = 8'h30;
  localparam logic [7:0] CH_9    = 8'h39;
  localparam logic [7:0] CH_LA   = 8'h61;
  localparam logic [7:0] CH_LF_A = 8'h66;
  localparam logic [7:0] CH_UA   = 8'h41;
  localparam logic [7:0] CH_UF   = 8'h46;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_LEN      = 3'd1,
    PH_LINE     = 3'd2,
    PH_SIZE     = 3'd3,
    PH_DATA     = 3'd4,
    PH_DATA_END = 3'd5,
    PH_DONE     = 3'd6,
    PH_ERR      = 3'd7
  } hbd_phase_e;

  typedef enum logic [1:0] {
    OK_BYTE = 2'd0,
    OK_DONE = 2'd1,
    OK_ERR  = 2'd2
  } hbd_okind_e;

  typedef enum logic [1:0] {
    ER_SHORT    = 2'd0,
    ER_NO_CRLF  = 2'd1,
    ER_SIZE     = 2'd2,
    ER_DATA_END = 2'd3
  } hbd_err_e;

  typedef struct packed {
    logic [1:0]          kind;
    logic [7:0]          data_byte;
    logic                chunked;
    logic                has_length;
    logic [DeclLenW-1:0] declared_length;
  } hbd_in_t;

  typedef struct packed {
    logic [1:0] out_kind;
    logic [7:0] body_byte;
    logic [1:0] error_code;
  } hbd_out_t;

  // result of one step: valid flag plus payload
  typedef struct packed {
    logic     valid;
    hbd_out_t item;
  } hbd_res_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hbd_hex_t;

  function automatic hbd_hex_t hbd_hex_decode(logic [7:0] c);
    hbd_hex_t r;
    r.ok  = 1'b1;
    r.val = 4'd0;
    if (c >= CH_0 && c <= CH_9) begin
      r.val = 4'(c - CH_0);
    end else if (c >= CH_LA && c <= CH_LF_A) begin
      r.val = 4'(c - CH_LA + 8'd10);
    end else if (c >= CH_UA && c <= CH_UF) begin
      r.val = 4'(c - CH_UA + 8'd10);
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

endpackage

// ----- design/hbd_in_stage.sv -----
// ----------------------------------------------------------------------------
// hbd_in_stage: input register
// Holds one accepted item until the decoder consumes it.
// ----------------------------------------------------------------------------
module hbd_in_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  hbd_pkg::hbd_in_t item_i,
  output logic             valid_o,
  output hbd_pkg::hbd_in_t item_o,
  input  logic             take_i
);
  import hbd_pkg::*;

  logic    vld_q, vld_d;
  hbd_in_t item_q;

  assign ready_o = !vld_q || take_i;
  assign vld_d   = (valid_i && ready_o) || (vld_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = vld_q;
  assign item_o  = item_q;

endmodule

// ----- design/hbd_core.sv -----
// ----------------------------------------------------------------------------
// hbd_core: framing state machine
// Phase, byte counter, chunk size parser and line-mode hold byte; one item
// per step.
// ----------------------------------------------------------------------------
module hbd_core #(
  parameter int unsigned LENGTH_BITS     = 32,
  parameter int unsigned CHUNK_SIZE_BITS = 24
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  hbd_pkg::hbd_in_t  item_i,
  input  logic              step_i,
  output hbd_pkg::hbd_res_t res_o
);
  import hbd_pkg::*;

  hbd_phase_e                 phase_q, phase_d;
  logic [LENGTH_BITS-1:0]     rem_q, rem_d;
  logic [CHUNK_SIZE_BITS-1:0] acc_q, acc_d;
  logic                       digit_q, digit_d;
  logic                       cr_q, cr_d;
  logic [7:0]                 hold_q, hold_d;
  logic                       hold_vld_q, hold_vld_d;

  logic [LENGTH_BITS-1:0]     start_len;
  logic [LENGTH_BITS-1:0]     chunk_len;
  logic [LENGTH_BITS-1:0]     rem_dec;
  hbd_hex_t                   hex;
  logic                       acc_full;
  logic [7:0]                 b;

  // saturate the declared length into the counter
  if (LENGTH_BITS >= DeclLenW) begin : g_len_wide
    assign start_len = LENGTH_BITS'(item_i.declared_length);
  end else begin : g_len_sat
    assign start_len = (|item_i.declared_length[DeclLenW-1:LENGTH_BITS]) ? '1 :
                       item_i.declared_length[LENGTH_BITS-1:0];
  end

  if (LENGTH_BITS >= CHUNK_SIZE_BITS) begin : g_chunk_wide
    assign chunk_len = LENGTH_BITS'(acc_q);
  end else begin : g_chunk_sat
    assign chunk_len = (|acc_q[CHUNK_SIZE_BITS-1:LENGTH_BITS]) ? '1 :
                       acc_q[LENGTH_BITS-1:0];
  end

  assign b        = item_i.data_byte;
  assign hex      = hbd_hex_decode(b);
  assign rem_dec  = rem_q - LENGTH_BITS'(1);
  assign acc_full = |acc_q[CHUNK_SIZE_BITS-1:CHUNK_SIZE_BITS-4];

  // next state
  always_comb begin
    phase_d    = phase_q;
    rem_d      = rem_q;
    acc_d      = acc_q;
    digit_d    = digit_q;
    cr_d       = cr_q;
    hold_d     = hold_q;
    hold_vld_d = hold_vld_q;
    case (item_i.kind)
      KIND_START: begin
        rem_d      = '0;
        acc_d      = '0;
        digit_d    = 1'b0;
        cr_d       = 1'b0;
        hold_d     = 8'd0;
        hold_vld_d = 1'b0;
        if (item_i.chunked) begin
          phase_d = PH_SIZE;
        end else if (item_i.has_length) begin
          rem_d   = start_len;
          phase_d = (item_i.declared_length == '0) ? PH_DONE : PH_LEN;
        end else if (item_i.declared_length == '0) begin
          phase_d = PH_DONE;
        end else begin
          phase_d = PH_LINE;
        end
      end
      KIND_DATA: begin
        case (phase_q)
          PH_LEN: begin
            rem_d = rem_dec;
            if (rem_dec == '0) phase_d = PH_DONE;
          end
          PH_LINE: begin
            if (hold_vld_q && hold_q == CH_CR && b == CH_LF) begin
              hold_vld_d = 1'b0;
              phase_d    = PH_DONE;
            end else begin
              hold_d     = b;
              hold_vld_d = 1'b1;
            end
          end
          PH_SIZE: begin
            if (cr_q) begin
              if (b != CH_LF) begin
                phase_d = PH_ERR;
              end else begin
                cr_d = 1'b0;
                if (acc_q == '0) begin
                  phase_d = PH_DONE;
                end else begin
                  rem_d   = chunk_len;
                  phase_d = PH_DATA;
                end
              end
            end else if (b == CH_CR) begin
              if (!digit_q) phase_d = PH_ERR;
              else          cr_d    = 1'b1;
            end else if (!hex.ok || acc_full) begin
              phase_d = PH_ERR;
            end else begin
              acc_d   = {acc_q[CHUNK_SIZE_BITS-5:0], hex.val};
              digit_d = 1'b1;
            end
          end
          PH_DATA: begin
            rem_d = rem_dec;
            if (rem_dec == '0) begin
              phase_d = PH_DATA_END;
              cr_d    = 1'b0;
            end
          end
          PH_DATA_END: begin
            if (!cr_q) begin
              if (b != CH_CR) phase_d = PH_ERR;
              else            cr_d    = 1'b1;
            end else if (b != CH_LF) begin
              phase_d = PH_ERR;
            end else begin
              phase_d = PH_SIZE;
              acc_d   = '0;
              digit_d = 1'b0;
              cr_d    = 1'b0;
            end
          end
          default: ;
        endcase
      end
      KIND_END: begin
        phase_d    = PH_IDLE;
        rem_d      = '0;
        acc_d      = '0;
        digit_d    = 1'b0;
        cr_d       = 1'b0;
        hold_d     = 8'd0;
        hold_vld_d = 1'b0;
      end
      default: ;
    endcase
  end

  // result
  always_comb begin
    res_o.valid           = 1'b0;
    res_o.item.out_kind   = OK_BYTE;
    res_o.item.body_byte  = 8'd0;
    res_o.item.error_code = ER_SHORT;
    case (item_i.kind)
      KIND_DATA: begin
        case (phase_q)
          PH_LEN, PH_DATA: begin
            res_o.valid          = 1'b1;
            res_o.item.body_byte = b;
          end
          PH_LINE: begin
            if (hold_vld_q && !(hold_q == CH_CR && b == CH_LF)) begin
              res_o.valid          = 1'b1;
              res_o.item.body_byte = hold_q;
            end
          end
          PH_SIZE: begin
            if ((cr_q && b != CH_LF) ||
                (!cr_q && b == CH_CR && !digit_q) ||
                (!cr_q && b != CH_CR && (!hex.ok || acc_full))) begin
              res_o.valid           = 1'b1;
              res_o.item.out_kind   = OK_ERR;
              res_o.item.error_code = ER_SIZE;
            end
          end
          PH_DATA_END: begin
            if ((!cr_q && b != CH_CR) || (cr_q && b != CH_LF)) begin
              res_o.valid           = 1'b1;
              res_o.item.out_kind   = OK_ERR;
              res_o.item.error_code = ER_DATA_END;
            end
          end
          default: ;
        endcase
      end
      KIND_END: begin
        case (phase_q)
          PH_DONE: begin
            res_o.valid         = 1'b1;
            res_o.item.out_kind = OK_DONE;
          end
          PH_LEN, PH_DATA: begin
            res_o.valid           = 1'b1;
            res_o.item.out_kind   = OK_ERR;
            res_o.item.error_code = ER_SHORT;
          end
          PH_LINE, PH_SIZE, PH_DATA_END: begin
            res_o.valid           = 1'b1;
            res_o.item.out_kind   = OK_ERR;
            res_o.item.error_code = ER_NO_CRLF;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      rem_q      <= '0;
      acc_q      <= '0;
      digit_q    <= 1'b0;
      cr_q       <= 1'b0;
      hold_q     <= 8'd0;
      hold_vld_q <= 1'b0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      rem_q      <= rem_d;
      acc_q      <= acc_d;
      digit_q    <= digit_d;
      cr_q       <= cr_d;
      hold_q     <= hold_d;
      hold_vld_q <= hold_vld_d;
    end
  end

  // counter never idles at zero while a length body is open
  a_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_LEN || phase_q == PH_DATA) |-> rem_q != '0)
    else $error("byte counter zero inside a counted body");

  // end item always returns to idle
  a_end_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && item_i.kind == KIND_END) |=> phase_q == PH_IDLE)
    else $error("end item did not return to idle");

  // body bytes only come from a body phase
  a_byte_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.item.out_kind == OK_BYTE) |->
      (phase_q == PH_LEN || phase_q == PH_LINE || phase_q == PH_DATA))
    else $error("body byte outside a body phase");

  // a protocol error on a data byte parks the decoder
  a_err_park: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && item_i.kind == KIND_DATA && res_o.valid &&
     res_o.item.out_kind == OK_ERR) |=> phase_q == PH_ERR)
    else $error("protocol error did not park the decoder");

endmodule

// ----- design/hbd_out_stage.sv -----
// ----------------------------------------------------------------------------
// hbd_out_stage: result register
// Holds one result item until the consumer takes it.
// ----------------------------------------------------------------------------
module hbd_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  hbd_pkg::hbd_out_t item_i,
  output logic              free_o,
  output logic              valid_o,
  input  logic              ready_i,
  output hbd_pkg::hbd_out_t item_o
);
  import hbd_pkg::*;

  logic     vld_q, vld_d;
  hbd_out_t item_q;

  assign free_o = !vld_q || ready_i;
  assign vld_d  = load_i || (vld_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = vld_q;
  assign item_o  = item_q;

endmodule

// ----- design/http_body_dechunker_top.sv -----
// ----------------------------------------------------------------------------
// http_body_dechunker_top: HTTP message body extractor
// Decodes chunked, counted or CRLF-terminated bodies from a byte stream.
// ----------------------------------------------------------------------------
//  channel  dir  handshake              payload
//  in       in   in_valid_i/in_ready_o   in_item_i   (hbd_in_t)
//  out      out  out_valid_o/out_ready_i out_item_o  (hbd_out_t)
//
//  One item per cycle sustained while the output is not stalled; each item
//  gives zero or one result, through the input and then the result register.
//  Reset clears phase, counters and both stage valid bits.
//  A stalled output holds the result register; items without a result still
//  pass, but an item with a result waits in the input register and in_ready_o
//  drops until the result is taken.
// ----------------------------------------------------------------------------
module http_body_dechunker_top #(
  parameter int unsigned LENGTH_BITS     = 32,
  parameter int unsigned CHUNK_SIZE_BITS = 24
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  hbd_pkg::hbd_in_t  in_item_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output hbd_pkg::hbd_out_t out_item_o
);
  import hbd_pkg::*;

  logic     stg_vld;
  hbd_in_t  stg_item;
  hbd_res_t res;
  logic     out_free;
  logic     step;

  hbd_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .item_i  (in_item_i),
    .valid_o (stg_vld),
    .item_o  (stg_item),
    .take_i  (step)
  );

  // an item that yields no result never waits for the output
  assign step = stg_vld && (!res.valid || out_free);

  hbd_core #(
    .LENGTH_BITS     (LENGTH_BITS),
    .CHUNK_SIZE_BITS (CHUNK_SIZE_BITS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (stg_item),
    .step_i (step),
    .res_o  (res)
  );

  hbd_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (step && res.valid),
    .item_i  (res.item),
    .free_o  (out_free),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .item_o  (out_item_o)
  );

endmodule
